### rtl/mcoc_pkg.sv
package mcoc_pkg;

  // Result sideband (out_tuser) layout
  localparam int USER_W      = 2;
  localparam int USR_SAT_BIT = 0;
  localparam int USR_BAD_BIT = 1;

  // Outermost split travels as a fixed 4-bit field
  localparam int SPLIT_W = 4;

endpackage

### rtl/matrix_chain_order_cost.sv
// Channel  | Dir | Ports                                   | Transaction
// ---------+-----+-----------------------------------------+----------------------------------
// in_      | in  | in_tvalid/in_tready/in_tdata/in_tlast   | one dimension p[k]; tlast on p[n]
// out_     | out | out_tvalid/out_tready/out_tdata/out_tuser | one result per chain
//
// Loading takes one cycle per dimension; the tlast transaction starts the table fill.
// For n matrices in_tready stays low while the table fills; each interval reads p[i], p[j+1],
// issues one split per cycle into the shared multiply / add / compare pipe, drains, stores.
// Too short or one-matrix chains skip the fill and go straight to the result hand-over.
// A stalled result holds back the next chain's finish, not its loading; reset (rst_n low,
// synchronous) clears the dimension count and the result valid, not the memories.
module matrix_chain_order_cost #(
  parameter int MAX_MATRICES = 16,
  parameter int DIM_BITS     = 12,
  parameter int COST_BITS    = 48,
  localparam int IN_DW  = ((DIM_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((COST_BITS + mcoc_pkg::SPLIT_W + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [IN_DW-1:0]            in_tdata,   // [DIM_BITS-1:0] dimension, rest zero
  input  logic                        in_tlast,   // last_dimension
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OUT_DW-1:0]           out_tdata,  // min_cost, then top_split (4b), zero pad
  output logic [mcoc_pkg::USER_W-1:0] out_tuser   // [0] cost_saturated, [1] bad_length
);

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int DEPTH_D = MAX_MATRICES + 1;          // dimension store entries
  localparam int IW      = $clog2(MAX_MATRICES);      // matrix index
  localparam int DW      = $clog2(DEPTH_D);           // dimension store address
  localparam int CW      = $clog2(MAX_MATRICES + 2);  // dimension count 0..DEPTH_D
  localparam int KW      = $clog2(MAX_MATRICES + 1);  // split value 1..MAX_MATRICES
  localparam int QW      = 2 * DIM_BITS;              // p[i]*p[j+1]
  localparam int PW      = 3 * DIM_BITS;              // full triple product
  localparam int AW      = COST_BITS + 1;             // sum of two table costs
  localparam int SW      = ((AW > PW) ? AW : PW) + 1; // exact candidate sum
  localparam int CA      = 2 * IW;                    // cost table address {row, col}
  localparam int CDEPTH  = 1 << CA;

  // At full 64-bit cost the clamp never reports: only sums above the field flag.
  localparam bit SAT_FLAG_EN = (COST_BITS < 64);
  localparam logic [SW-1:0] COST_MAX_W = SW'({COST_BITS{1'b1}});

  // Sequencer codes
  localparam logic [2:0] S_LOAD  = 3'd0;  // taking dimensions
  localparam logic [2:0] S_PRE   = 3'd1;  // read p[i], p[j+1]
  localparam logic [2:0] S_PRE2  = 3'd2;  // p[i]*p[j+1] through the multiplier
  localparam logic [2:0] S_RUN   = 3'd3;  // issue one split k per cycle
  localparam logic [2:0] S_DRAIN = 3'd4;  // let the pipe empty
  localparam logic [2:0] S_WRITE = 3'd5;  // store m[i][j], step interval
  localparam logic [2:0] S_DONE  = 3'd6;  // hand result to output register

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 too_many_r, too_many_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 have_r, have_nxt;
  logic                 v1_r, v1_nxt;
  logic                 v2_r, v2_nxt;
  logic                 v3_r, v3_nxt;

  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        len_r, len_nxt;
  logic [IW-1:0]        i_r, i_nxt;
  logic [IW-1:0]        j_r, j_nxt;
  logic [IW-1:0]        k_r, k_nxt;
  logic [QW-1:0]        pij_r, pij_nxt;
  logic                 bad_r, bad_nxt;

  logic                 z1a_r, z1a_nxt;
  logic                 z1b_r, z1b_nxt;
  logic [IW-1:0]        k1_r, k1_nxt;
  logic [PW-1:0]        prod2_r, prod2_nxt;
  logic [AW-1:0]        ab2_r, ab2_nxt;
  logic [IW-1:0]        k2_r, k2_nxt;
  logic [COST_BITS-1:0] q3_r, q3_nxt;
  logic                 sat3_r, sat3_nxt;
  logic [IW-1:0]        k3_r, k3_nxt;
  logic [COST_BITS-1:0] best_r, best_nxt;
  logic [KW-1:0]        best_k_r, best_k_nxt;

  logic [COST_BITS-1:0]        cost_out_r, cost_out_nxt;
  logic [mcoc_pkg::SPLIT_W-1:0] split_out_r, split_out_nxt;
  logic                        sat_out_r, sat_out_nxt;
  logic                        bad_out_r, bad_out_nxt;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic                 dim_we;
  logic [DW-1:0]        dim_waddr, dim_ra, dim_rb;
  logic [DIM_BITS-1:0]  dim_qa, dim_qb;
  logic                 cost_we;
  logic [CA-1:0]        cost_waddr, cost_ra, cost_rb;
  logic [COST_BITS-1:0] cost_qa, cost_qb;

  mcoc_ram #(.WIDTH(DIM_BITS), .DEPTH(DEPTH_D)) u_dim_ram (
    .clk       (clk),
    .wr_en     (dim_we),
    .wr_addr   (dim_waddr),
    .wr_data   (in_tdata[DIM_BITS-1:0]),
    .rd_addr_a (dim_ra),
    .rd_data_a (dim_qa),
    .rd_addr_b (dim_rb),
    .rd_data_b (dim_qb)
  );

  mcoc_ram #(.WIDTH(COST_BITS), .DEPTH(CDEPTH)) u_cost_ram (
    .clk       (clk),
    .wr_en     (cost_we),
    .wr_addr   (cost_waddr),
    .wr_data   (best_r),
    .rd_addr_a (cost_ra),
    .rd_data_a (cost_qa),
    .rd_addr_b (cost_rb),
    .rd_data_b (cost_qb)
  );

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic                 accept;
  logic                 store_ok;
  logic [CW-1:0]        count_after;
  logic [IW-1:0]        k_plus;
  logic [QW-1:0]        mul_a;
  logic [DIM_BITS-1:0]  mul_b;
  logic [PW-1:0]        mul_p;
  logic [COST_BITS-1:0] ca_eff, cb_eff;
  logic [SW-1:0]        cand_sum;
  logic                 cand_over;
  logic                 take;
  logic [CW:0]          next_end;
  logic [KW+mcoc_pkg::SPLIT_W-1:0] split_ext;

  assign in_tready   = (state_r == S_LOAD);
  assign accept      = in_tvalid && in_tready;
  assign store_ok    = (count_r < CW'(DEPTH_D));
  assign count_after = store_ok ? (count_r + CW'(1)) : count_r;

  assign k_plus = k_r + IW'(1);

  // dimension store: write while loading, read p[i]/p[k+1] on port a, p[j+1] on b
  assign dim_we    = accept && store_ok;
  assign dim_waddr = count_r[DW-1:0];
  assign dim_ra    = (state_r == S_PRE) ? DW'(i_r) : DW'(k_plus);
  assign dim_rb    = DW'(i_r) + DW'(len_r);

  // cost table: m[i][k] on port a, m[k+1][j] on port b
  assign cost_ra    = {i_r, k_r};
  assign cost_rb    = {k_plus, j_r};
  assign cost_we    = (state_r == S_WRITE);
  assign cost_waddr = {i_r, j_r};

  // shared multiplier: p[i]*p[j+1] during setup, then (p[i]*p[j+1])*p[k+1] per split
  assign mul_a = (state_r == S_PRE2) ? QW'(dim_qa) : pij_r;
  assign mul_b = (state_r == S_PRE2) ? dim_qb : dim_qa;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // diagonal entries are zero and never stored
  assign ca_eff = z1a_r ? '0 : cost_qa;
  assign cb_eff = z1b_r ? '0 : cost_qb;

  assign cand_sum  = SW'(ab2_r) + SW'(prod2_r);
  assign cand_over = (cand_sum > COST_MAX_W);

  // first candidate wins ties
  assign take = v3_r && (!have_r || (q3_r < best_r));

  assign next_end  = (CW+1)'(i_r) + (CW+1)'(len_r) + (CW+1)'(1);
  assign split_ext = (KW + mcoc_pkg::SPLIT_W)'(best_k_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    too_many_nxt  = too_many_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    have_nxt      = have_r;
    n_nxt         = n_r;
    len_nxt       = len_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    pij_nxt       = pij_r;
    bad_nxt       = bad_r;
    best_nxt      = best_r;
    best_k_nxt    = best_k_r;
    cost_out_nxt  = cost_out_r;
    split_out_nxt = split_out_r;
    sat_out_nxt   = sat_out_r;
    bad_out_nxt   = bad_out_r;

    // pipe stages advance every cycle
    v1_nxt    = 1'b0;
    z1a_nxt   = z1a_r;
    z1b_nxt   = z1b_r;
    k1_nxt    = k1_r;
    v2_nxt    = v1_r;
    prod2_nxt = v1_r ? mul_p : prod2_r;
    ab2_nxt   = v1_r ? (AW'(ca_eff) + AW'(cb_eff)) : ab2_r;
    k2_nxt    = v1_r ? k1_r : k2_r;
    v3_nxt    = v2_r;
    q3_nxt    = v2_r ? (cand_over ? COST_MAX_W[COST_BITS-1:0] : cand_sum[COST_BITS-1:0])
                     : q3_r;
    sat3_nxt  = v2_r ? (cand_over && SAT_FLAG_EN) : sat3_r;
    k3_nxt    = v2_r ? k2_r : k3_r;

    if (take) begin
      have_nxt   = 1'b1;
      best_nxt   = q3_r;
      best_k_nxt = KW'(k3_r) + KW'(1);
    end
    if (v3_r && sat3_r) begin
      ovf_nxt = 1'b1;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (accept) begin
          count_nxt = count_after;
          if (!store_ok) begin
            too_many_nxt = 1'b1;
          end
          if (in_tlast) begin
            bad_nxt    = too_many_r || !store_ok || (count_after < CW'(2));
            best_nxt   = '0;
            best_k_nxt = '0;
            if (count_after > CW'(2)) begin
              n_nxt     = count_after - CW'(1);
              len_nxt   = CW'(2);
              i_nxt     = '0;
              state_nxt = S_PRE;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_PRE: begin
        j_nxt     = IW'(DW'(i_r) + DW'(len_r) - DW'(1));
        k_nxt     = i_r;
        have_nxt  = 1'b0;
        state_nxt = S_PRE2;
      end
      S_PRE2: begin
        pij_nxt   = mul_p[QW-1:0];
        state_nxt = S_RUN;
      end
      S_RUN: begin
        v1_nxt  = 1'b1;
        z1a_nxt = (k_r == i_r);
        z1b_nxt = (k_plus == j_r);
        k1_nxt  = k_r;
        if (k_plus == j_r) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_plus;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (len_r == n_r) begin
          state_nxt = S_DONE;
        end else if (next_end > (CW+1)'(n_r)) begin
          len_nxt   = len_r + CW'(1);
          i_nxt     = '0;
          state_nxt = S_PRE;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_PRE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cost_out_nxt  = best_r;
          split_out_nxt = split_ext[mcoc_pkg::SPLIT_W-1:0];
          sat_out_nxt   = ovf_r;
          bad_out_nxt   = bad_r;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          too_many_nxt  = 1'b0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      too_many_r  <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      too_many_r  <= too_many_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
    end
  end

  // payload and loop registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    len_r       <= len_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    pij_r       <= pij_nxt;
    bad_r       <= bad_nxt;
    z1a_r       <= z1a_nxt;
    z1b_r       <= z1b_nxt;
    k1_r        <= k1_nxt;
    prod2_r     <= prod2_nxt;
    ab2_r       <= ab2_nxt;
    k2_r        <= k2_nxt;
    q3_r        <= q3_nxt;
    sat3_r      <= sat3_nxt;
    k3_r        <= k3_nxt;
    best_r      <= best_nxt;
    best_k_r    <= best_k_nxt;
    cost_out_r  <= cost_out_nxt;
    split_out_r <= split_out_nxt;
    sat_out_r   <= sat_out_nxt;
    bad_out_r   <= bad_out_nxt;
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({split_out_r, cost_out_r});
  assign out_tuser[mcoc_pkg::USR_SAT_BIT] = sat_out_r;
  assign out_tuser[mcoc_pkg::USR_BAD_BIT] = bad_out_r;

endmodule

### rtl/mcoc_ram.sv
module mcoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### rtl/mcoc_checker.sv
module mcoc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        in_tlast,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [mcoc_pkg::USER_W-1:0] out_tuser
);

  // reset leaves the block empty and ready to load
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("not ready or result pending after reset");

  // closing a chain starts the table fill or the result hand-over; no further dimension is taken
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("dimension accepted right after end of chain");

  // a new result only appears out of a busy period
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised while loading");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped before transaction");

  a_user_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tuser))
    else $error("result flags changed while stalled");

endmodule

bind matrix_chain_order_cost mcoc_checker u_mcoc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser)
);
